@@ rtl/uvsg_pkg.sv @@
`default_nettype none

package uvsg_pkg;

   // fixed geometry of the datapath
   localparam int CORE_BITS      = 30;
   localparam int CORE_WIDTH     = 34;
   localparam int DIV_STEPS      = 33;
   localparam int MAX_RINGS      = 1024;
   localparam int MAX_SEGMENTS   = 1024;
   localparam int CORDIC_GAIN    = 652032874;
   localparam int CORDIC_STAGES_DEFAULT = 20;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // configuration register indexes
   localparam logic [2:0] CSR_CENTER_X      = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z      = 3'd2;
   localparam logic [2:0] CSR_RADIUS        = 3'd3;
   localparam logic [2:0] CSR_RING_COUNT    = 3'd4;
   localparam logic [2:0] CSR_SEGMENT_COUNT = 3'd5;

   // item tag that travels beside the datapath
   typedef struct packed {
      logic        err;
      logic [20:0] vnum;
      logic        flip_t;
      logic        flip_p;
   } side_type;

   // arctangent of 2^-i in binary turns, 2^32 = one turn
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uvsg_div_cell.sv @@
`default_nettype none

module uvsg_div_cell import uvsg_pkg::*; #(
   parameter bit FIRST = 1'b0
) (
   input  wire logic        clock,
   input  wire logic [10:0] divisor,
   input  wire logic [10:0] rem_in,
   input  wire logic [32:0] quo_in,
   output logic      [10:0] rem_out,
   output logic      [32:0] quo_out
);

   logic [11:0] trial;
   logic        take;

   // one restoring step: shift in a zero (the first cell does not shift), subtract when it fits
   always_comb begin
      trial = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
      take  = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      rem_out <= take ? 11'(trial - {1'b0, divisor}) : trial[10:0];
      quo_out <= {quo_in[31:0], take};
   end

endmodule

`default_nettype wire

@@ rtl/uvsg_cordic_cell.sv @@
`default_nettype none

module uvsg_cordic_cell import uvsg_pkg::*; #(
   parameter int IDX = 0
) (
   input  wire logic                         clock,
   input  wire logic signed [CORE_WIDTH-1:0] x_in,
   input  wire logic signed [CORE_WIDTH-1:0] y_in,
   input  wire logic signed [CORE_WIDTH-1:0] z_in,
   output logic      signed [CORE_WIDTH-1:0] x_out,
   output logic      signed [CORE_WIDTH-1:0] y_out,
   output logic      signed [CORE_WIDTH-1:0] z_out
);

   localparam logic signed [CORE_WIDTH-1:0] ATAN =
      signed'(CORE_WIDTH'(atan_turn(IDX)));

   logic signed [CORE_WIDTH-1:0] dx;
   logic signed [CORE_WIDTH-1:0] dy;

   always_comb begin
      dx = x_in >>> IDX;
      dy = y_in >>> IDX;
   end

   // rotate toward zero residual angle
   always_ff @(posedge clock) begin
      if (!z_in[CORE_WIDTH-1]) begin
         x_out <= x_in - dy;
         y_out <= y_in + dx;
         z_out <= z_in - ATAN;
      end else begin
         x_out <= x_in + dy;
         y_out <= y_in - dx;
         z_out <= z_in + ATAN;
      end
   end

endmodule

`default_nettype wire

@@ rtl/uv_sphere_vertex_generator_unit.sv @@
// throughput: one vertex per cycle, every cycle outside reset; a 33-cell divider chain and a
//   CORDIC_STAGES-cell rotation chain per angle carry one item per cell
// busy is high only during reset; the receiver cannot stall
// reset: synchronous, restores register defaults and drops items in flight
`default_nettype none

module uv_sphere_vertex_generator_unit import uvsg_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_start,
   output logic                    req_busy,
   input  wire logic [10:0]        req_ring_index,
   input  wire logic [9:0]         req_segment_index,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic [20:0]             rsp_vertex_number,
   output logic                    rsp_index_error,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);

   localparam int N    = CORDIC_STAGES;
   localparam int F    = FRACTION_BITS;
   localparam int CW   = CORE_WIDTH;
   localparam int TW   = F + 2;
   localparam int PW   = TW + 32;
   localparam int SH   = CORE_BITS - F;
   localparam int FS   = DIV_STEPS + 1;
   localparam int LAT  = FS + N + 3;
   localparam logic signed [CW-1:0] RND_C  = signed'(CW'(1) << (SH - 1));
   localparam logic signed [2*TW-1:0] RND_A = signed'((2*TW)'(1) << (F - 1));
   localparam logic signed [PW-1:0]  RND_B  = signed'(PW'(1) << (F - 1));
   localparam logic signed [CW-1:0] GAIN   = signed'(CW'(CORDIC_GAIN));
   localparam logic signed [PW:0]   SMAX   = signed'((PW+1)'(33'h0_7FFF_FFFF));
   localparam logic signed [PW:0]   SMIN   = ~SMAX;

   // configuration registers
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        radius_ff;
   logic [10:0]        ring_count_ff, segment_count_ff;
   logic [10:0]        rings, segs;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         center_z_ff      <= '0;
         radius_ff        <= 31'd65536;
         ring_count_ff    <= 11'd16;
         segment_count_ff <= 11'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CENTER_X:      center_x_ff      <= csr_write_data;
            CSR_CENTER_Y:      center_y_ff      <= csr_write_data;
            CSR_CENTER_Z:      center_z_ff      <= csr_write_data;
            CSR_RADIUS:        radius_ff        <= csr_write_data[30:0];
            CSR_RING_COUNT:    ring_count_ff    <= csr_write_data[10:0];
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   // clamp counts to the supported grid
   always_comb begin
      rings = (32'(ring_count_ff) > 32'(MAX_RINGS)) ? 11'(MAX_RINGS) : ring_count_ff;
      segs  = (32'(segment_count_ff) > 32'(MAX_SEGMENTS)) ?
              11'(MAX_SEGMENTS) : segment_count_ff;
   end

   // input stage: range check and flat vertex number
   logic             accept;
   logic             vld_ff [LAT];
   side_type         side_ff [LAT];
   logic [10:0]      num_t_ff, num_p_ff;
   logic             in_err;
   logic [21:0]      in_prod;
   logic             flip_t, flip_p;

   assign req_busy = reset;
   assign accept   = req_start && !req_busy;

   always_comb begin
      in_err  = (rings == 11'd0) || (segs == 11'd0) || (req_ring_index > rings) ||
                ({1'b0, req_segment_index} >= segs);
      in_prod = req_ring_index * segs;
   end

   always_ff @(posedge clock) begin
      num_t_ff     <= {1'b0, req_segment_index};
      num_p_ff     <= req_ring_index;
      side_ff[0].err    <= in_err;
      side_ff[0].vnum   <= 21'(in_prod + 22'(req_segment_index));
      side_ff[0].flip_t <= 1'b0;
      side_ff[0].flip_p <= 1'b0;
      for (int k = 1; k < LAT; k++) begin
         if (k == FS) begin
            side_ff[k].err    <= side_ff[k-1].err;
            side_ff[k].vnum   <= side_ff[k-1].vnum;
            side_ff[k].flip_t <= flip_t;
            side_ff[k].flip_p <= flip_p;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // valid bit shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // phase dividers: q = floor(n * 2^32 / d), one quotient bit per cell
   logic [10:0] rt_w [DIV_STEPS+1];
   logic [10:0] rp_w [DIV_STEPS+1];
   logic [32:0] qt_w [DIV_STEPS+1];
   logic [32:0] qp_w [DIV_STEPS+1];

   assign rt_w[0] = num_t_ff;
   assign rp_w[0] = num_p_ff;
   assign qt_w[0] = '0;
   assign qp_w[0] = '0;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      uvsg_div_cell #(.FIRST(k == 0)) u_div_t (
         .clock(clock), .divisor(segs), .rem_in(rt_w[k]), .quo_in(qt_w[k]),
         .rem_out(rt_w[k+1]), .quo_out(qt_w[k+1])
      );
      uvsg_div_cell #(.FIRST(k == 0)) u_div_p (
         .clock(clock), .divisor(rings), .rem_in(rp_w[k]), .quo_in(qp_w[k]),
         .rem_out(rp_w[k+1]), .quo_out(qp_w[k+1])
      );
   end

   // quadrant fold: second and third quadrant turn by a half turn
   logic [31:0] ph_t, ph_p;
   logic signed [CW-1:0] xt_w [N+1], yt_w [N+1], zt_w [N+1];
   logic signed [CW-1:0] xp_w [N+1], yp_w [N+1], zp_w [N+1];

   always_comb begin
      ph_t   = qt_w[DIV_STEPS][31:0];
      ph_p   = qp_w[DIV_STEPS][32:1];
      flip_t = ph_t[31] ^ ph_t[30];
      flip_p = ph_p[31] ^ ph_p[30];
   end

   assign xt_w[0] = GAIN;
   assign yt_w[0] = '0;
   assign zt_w[0] = CW'(signed'({ph_t[31] ^ flip_t, ph_t[30:0]}));
   assign xp_w[0] = GAIN;
   assign yp_w[0] = '0;
   assign zp_w[0] = CW'(signed'({ph_p[31] ^ flip_p, ph_p[30:0]}));

   // rotation chains
   for (genvar j = 0; j < N; j++) begin : g_cordic
      uvsg_cordic_cell #(.IDX(j)) u_rot_t (
         .clock(clock), .x_in(xt_w[j]), .y_in(yt_w[j]), .z_in(zt_w[j]),
         .x_out(xt_w[j+1]), .y_out(yt_w[j+1]), .z_out(zt_w[j+1])
      );
      uvsg_cordic_cell #(.IDX(j)) u_rot_p (
         .clock(clock), .x_in(xp_w[j]), .y_in(yp_w[j]), .z_in(zp_w[j]),
         .x_out(xp_w[j+1]), .y_out(yp_w[j+1]), .z_out(zp_w[j+1])
      );
   end

   // round to output fraction and undo the fold
   logic signed [TW-1:0] ct_ff, st_ff, cp_ff, sp_ff;
   logic signed [CW-1:0] ct_r, st_r, cp_r, sp_r;
   side_type             sr;

   always_comb begin
      sr   = side_ff[FS+N-1];
      ct_r = (xt_w[N] + RND_C) >>> SH;
      st_r = (yt_w[N] + RND_C) >>> SH;
      cp_r = (xp_w[N] + RND_C) >>> SH;
      sp_r = (yp_w[N] + RND_C) >>> SH;
   end

   always_ff @(posedge clock) begin
      ct_ff <= sr.flip_t ? -TW'(ct_r) : TW'(ct_r);
      st_ff <= sr.flip_t ? -TW'(st_r) : TW'(st_r);
      cp_ff <= sr.flip_p ? -TW'(cp_r) : TW'(cp_r);
      sp_ff <= sr.flip_p ? -TW'(sp_r) : TW'(sp_r);
   end

   // direction products
   logic signed [2*TW-1:0] pxa_ff, pya_ff;
   logic signed [TW-1:0]   cpa_ff;

   always_ff @(posedge clock) begin
      pxa_ff <= ct_ff * sp_ff;
      pya_ff <= st_ff * sp_ff;
      cpa_ff <= cp_ff;
   end

   // radius products
   logic signed [PW-1:0]   pxb_ff, pyb_ff, pzb_ff;
   logic signed [2*TW-1:0] ux_r, uy_r;
   logic signed [32:0]     rad_s;

   always_comb begin
      ux_r  = (pxa_ff + RND_A) >>> F;
      uy_r  = (pya_ff + RND_A) >>> F;
      rad_s = signed'({2'b00, radius_ff});
   end

   always_ff @(posedge clock) begin
      pxb_ff <= PW'(TW'(ux_r)) * PW'(rad_s);
      pyb_ff <= PW'(TW'(uy_r)) * PW'(rad_s);
      pzb_ff <= PW'(cpa_ff) * PW'(rad_s);
   end

   // center offset with saturation
   function automatic logic signed [31:0] place(input logic signed [31:0] ctr,
                                                input logic signed [PW-1:0] prod);
      logic signed [PW-1:0] term;
      logic signed [PW:0]   sum;
      term = (prod + RND_B) >>> F;
      sum  = (PW+1)'(ctr) + (PW+1)'(term);
      if (sum > SMAX)      return 32'sh7FFF_FFFF;
      else if (sum < SMIN) return 32'sh8000_0000;
      else                 return sum[31:0];
   endfunction

   side_type so;
   logic     strobe_ff;

   assign so = side_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= vld_ff[LAT-1];
   end

   always_ff @(posedge clock) begin
      rsp_index_error   <= so.err;
      rsp_vertex_number <= so.err ? 21'd0 : so.vnum;
      rsp_pos_x         <= so.err ? 32'sd0 : place(center_x_ff, pxb_ff);
      rsp_pos_y         <= so.err ? 32'sd0 : place(center_y_ff, pyb_ff);
      rsp_pos_z         <= so.err ? 32'sd0 : place(center_z_ff, pzb_ff);
   end

   assign rsp_strobe = strobe_ff;

   // checks
   a_entry: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] == $past(accept)) else $error("input stage valid mismatch");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_error) |->
      (rsp_pos_x == 32'sd0 && rsp_pos_y == 32'sd0 && rsp_pos_z == 32'sd0 &&
       rsp_vertex_number == 21'd0)) else $error("error result not zeroed");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] |=> rsp_strobe) else $error("result strobe lost");

endmodule

`default_nettype wire
